[rtl/core/lfr_pkg.sv]
package lfr_pkg;

	localparam int NUM_FRAMES  = 64;
	localparam int FRAME_SPACE = 64;
	localparam int FRAME_W     = 6;
	localparam int CAP_W       = 7;
	localparam int ENT_W       = 7;
	localparam int AW          = $clog2(NUM_FRAMES);
	localparam int CNT_W       = $clog2(NUM_FRAMES + 1);
	localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [1:0] {
		OP_VICTIM = 2'd0,
		OP_PIN    = 2'd1,
		OP_UNPIN  = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [FRAME_W-1:0] frame;
	} req_t;

	typedef struct packed {
		logic               done;
		logic [FRAME_W-1:0] victim;
		logic [ENT_W-1:0]   entry_count;
	} res_t;

endpackage

[rtl/core/lfr_ram.sv]
module lfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/lfr_engine.sv]
module lfr_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  lfr_pkg::req_t             req,
	input  logic [lfr_pkg::CAP_W-1:0] cap,
	output logic                      res_valid,
	input  logic                      slot_free,
	output lfr_pkg::res_t             res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t                             state_q;
	lfr_pkg::op_t                       op_q;
	logic [lfr_pkg::FRAME_W-1:0]        frame_q;
	logic [lfr_pkg::CNT_W-1:0]          cnt_q;
	logic [lfr_pkg::FRAME_SPACE-1:0]    flags_q;
	logic [lfr_pkg::CNT_W-1:0]          rd_q;
	logic                               found_q;
	logic                               done_q;
	logic [lfr_pkg::FRAME_W-1:0]        victim_q;
	logic                               rv_s1;
	logic [lfr_pkg::AW-1:0]             ridx_s1;

	logic                               issue;
	logic                               match;
	logic                               last;
	logic                               unpin_ok;
	logic                               ram_we;
	logic [lfr_pkg::AW-1:0]             ram_waddr;
	logic [lfr_pkg::FRAME_W-1:0]        ram_wdata;
	logic [lfr_pkg::FRAME_W-1:0]        ram_rdata;
	logic [lfr_pkg::CMP_W-1:0]          cnt_ext;

	assign issue    = (state_q == ST_WALK) && (rd_q < cnt_q);
	assign match    = (op_q == lfr_pkg::OP_VICTIM) ? (ridx_s1 == '0) : (ram_rdata == frame_q);
	assign last     = (lfr_pkg::CNT_W'(ridx_s1) + lfr_pkg::CNT_W'(1)) == cnt_q;
	assign unpin_ok = (lfr_pkg::CMP_W'(cnt_q) < lfr_pkg::CMP_W'(cap))
		&& (cnt_q < lfr_pkg::CNT_W'(lfr_pkg::NUM_FRAMES))
		&& !flags_q[req.frame];

	// Entries behind the removed one move down by one place as the walk reads them.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ridx_s1 - lfr_pkg::AW'(1);
		ram_wdata = ram_rdata;
		if (state_q == ST_IDLE) begin
			ram_we    = req_valid && (req.op == lfr_pkg::OP_UNPIN) && unpin_ok;
			ram_waddr = cnt_q[lfr_pkg::AW-1:0];
			ram_wdata = req.frame;
		end else if (state_q == ST_WALK) begin
			ram_we = rv_s1 && found_q;
		end
	end

	lfr_ram #(
		.WIDTH(lfr_pkg::FRAME_W),
		.DEPTH(lfr_pkg::NUM_FRAMES)
	) u_order_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_q[lfr_pkg::AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			flags_q <= '0;
			rd_q    <= '0;
			found_q <= 1'b0;
			rv_s1   <= 1'b0;
		end else begin
			rv_s1   <= issue;
			ridx_s1 <= rd_q[lfr_pkg::AW-1:0];
			if (issue) begin
				rd_q <= rd_q + lfr_pkg::CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q     <= req.op;
						frame_q  <= req.frame;
						done_q   <= 1'b0;
						victim_q <= '0;
						found_q  <= 1'b0;
						rd_q     <= '0;
						unique case (req.op)
							lfr_pkg::OP_VICTIM: begin
								state_q <= (cnt_q != '0) ? ST_WALK : ST_FIN;
							end
							lfr_pkg::OP_PIN: begin
								state_q <= flags_q[req.frame] ? ST_WALK : ST_FIN;
							end
							lfr_pkg::OP_UNPIN: begin
								if (unpin_ok) begin
									flags_q[req.frame] <= 1'b1;
									cnt_q              <= cnt_q + lfr_pkg::CNT_W'(1);
									done_q             <= 1'b1;
								end
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (rv_s1) begin
						if (!found_q && match) begin
							found_q            <= 1'b1;
							done_q             <= 1'b1;
							flags_q[ram_rdata] <= 1'b0;
							if (op_q == lfr_pkg::OP_VICTIM) begin
								victim_q <= ram_rdata;
							end
						end
						if (last) begin
							cnt_q   <= cnt_q - lfr_pkg::CNT_W'(1);
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cnt_ext         = lfr_pkg::CMP_W'(cnt_q);
	assign req_ready       = (state_q == ST_IDLE);
	assign res_valid       = (state_q == ST_FIN);
	assign res.done        = done_q;
	assign res.victim      = victim_q;
	assign res.entry_count = cnt_ext[lfr_pkg::ENT_W-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lfr_pkg::CNT_W'(lfr_pkg::NUM_FRAMES))
		else $error("entry count exceeds list depth");

	a_flags_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_WALK) |-> ($countones(flags_q) == int'(cnt_q)))
		else $error("present flags disagree with entry count");

	a_walk_removes_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && rv_s1 && last)
		|=> (cnt_q == $past(cnt_q) - lfr_pkg::CNT_W'(1)) && done_q)
		else $error("walk finished without removing one entry");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rv_s1)
		else $error("list read still in flight while idle");

endmodule

[rtl/core/lru_frame_replacer.sv]
// Unpin, an unused code, a victim on an empty list and a pin of an absent frame go straight to
// the finish state; the result is registered into the output slot once it is free, and then a new request is taken.
// Pin and victim walk the order list through one RAM read port and one compare, one entry a
// cycle over all entries held, and then hand the result to the output slot the same way.
// The asynchronous reset empties the list, clears all present flags and sets capacity to 64.
// The order list RAM is not cleared; entries at or above the count are never read.
module lru_frame_replacer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [5:0] frame_number, [7:6] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [5:0] victim_frame, [12:6] entry_count, [15:13] zero
	output logic        m_axis_tuser,   // [0] done_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data        // [6:0] capacity
);

	logic [lfr_pkg::CAP_W-1:0] cap_q;
	logic                      out_valid_q;
	lfr_pkg::res_t             out_res_q;
	lfr_pkg::req_t             req;
	lfr_pkg::res_t             res;
	logic                      res_valid;
	logic                      slot_free;

	assign req.op    = lfr_pkg::op_t'(s_axis_tuser);
	assign req.frame = s_axis_tdata[lfr_pkg::FRAME_W-1:0];
	assign slot_free = !out_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	lfr_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_axis_tvalid),
		.req_ready(s_axis_tready),
		.req      (req),
		.cap      (cap_q),
		.res_valid(res_valid),
		.slot_free(slot_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= lfr_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (res_valid && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && slot_free) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.done;
	assign m_axis_tdata  = {3'b000, out_res_q.entry_count, out_res_q.victim};

endmodule
